### hdl/bve_pkg.sv
// Shared types, codes and helpers for the B-spline volume evaluator.
// No dependencies; imported by bve_basis, bspline_volume_evaluator_core and bve_checker.
`default_nettype none

package bve_pkg;

  localparam int PTS_AXIS    = 8;
  localparam int IDX_BITS    = 3;
  localparam int ADDR_BITS   = 3 * IDX_BITS;
  localparam int STORE_DEPTH = PTS_AXIS * PTS_AXIS * PTS_AXIS;
  localparam int COORD_BITS  = 32;
  localparam int PARAM_BITS  = 18;
  localparam int WEIGHT_BITS = 32;

  // Request kinds carried on s_tuser
  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_POS   = 3'd1,
    REQ_DU    = 3'd2,
    REQ_DV    = 3'd3,
    REQ_DW    = 3'd4
  } req_type_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_COUNT_U  = 3'd0;
  localparam logic [2:0] CFG_COUNT_V  = 3'd1;
  localparam logic [2:0] CFG_COUNT_W  = 3'd2;
  localparam logic [2:0] CFG_DEGREE_U = 3'd3;
  localparam logic [2:0] CFG_DEGREE_V = 3'd4;
  localparam logic [2:0] CFG_DEGREE_W = 3'd5;

  // Request to the per-axis basis engine
  typedef struct packed {
    logic                          start;
    logic [3:0]                    count;
    logic [2:0]                    degree;
    logic signed [PARAM_BITS-1:0]  param;
    logic                          deriv;
  } basis_req_t;

  // Weight writes and completion from the basis engine
  typedef struct packed {
    logic                          wvalid;
    logic [IDX_BITS-1:0]           windex;
    logic signed [WEIGHT_BITS-1:0] wdata;
    logic                          done;
    logic [IDX_BITS-1:0]           first;
  } basis_rsp_t;

  // Arithmetic shift right, rounded to nearest, ties away from zero
  function automatic logic signed [71:0] round_shift(input logic signed [71:0] x,
                                                     input int unsigned sh);
    logic [71:0] mag;
    logic [71:0] r;
    mag = x[71] ? 72'(-x) : 72'(x);
    r   = (mag + (72'd1 << (sh - 1))) >> sh;
    return x[71] ? -$signed(r) : $signed(r);
  endfunction

endpackage

`default_nettype wire

### hdl/bve_basis.sv
// Per-axis Cox-de Boor basis engine: recursion with a shared multiply and
// a serial small-divisor divider. Depends on bve_pkg.
`default_nettype none

module bve_basis import bve_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  basis_req_t req,
  output basis_rsp_t rsp
);

  typedef enum logic [3:0] {
    B_IDLE, B_ENTRY, B_TERM, B_MUL, B_NUM, B_DIV, B_ACC, B_WRITE, B_OUT, B_DONE
  } bstate_t;

  bstate_t state;

  logic [3:0]         m_r;
  logic [2:0]         d_r;
  logic [2:0]         i_r;
  logic [19:0]        s_r;
  logic               deriv_r;
  logic [2:0]         j_r;
  logic [2:0]         r_r;
  logic [1:0]         term_r;
  logic [2:0]         kout_r;

  // Working basis values, indexed by distance below the active span
  logic signed [35:0] bq  [PTS_AXIS];
  logic signed [35:0] dbq [PTS_AXIS];
  logic signed [35:0] cur_b, cur_db, prev_b, prev_db;
  logic signed [39:0] nb, nd;

  // Term operands and arithmetic pipeline
  logic signed [20:0] op_n;
  logic signed [35:0] op_m;
  logic signed [47:0] op_add;
  logic [3:0]         op_span;
  logic               op_dst;
  logic signed [39:0] p_lo;
  logic signed [38:0] p_hi;
  logic [47:0]        dv;
  logic [3:0]         rem;
  logic [2:0]         div_cnt;
  logic               neg;

  function automatic logic [3:0] knot_at(input logic [4:0] x, input logic [2:0] dg,
                                         input logic [3:0] mm);
    logic signed [5:0] v;
    v = $signed({1'b0, x}) - $signed({3'b0, dg});
    if (v < 0) return 4'd0;
    else if (v > $signed({2'b0, mm})) return mm;
    else return v[3:0];
  endfunction

  // Start-up values from the request
  logic [3:0]  st_m;
  logic [19:0] st_mt;
  logic        t_low, t_high;
  logic [2:0]  st_i;
  logic [19:0] st_s;

  always_comb begin
    st_m   = req.count - {1'b0, req.degree};
    st_mt  = 20'(st_m) * 20'(req.param[15:0]);
    t_low  = req.param[PARAM_BITS-1] || (req.param == '0);
    t_high = !req.param[PARAM_BITS-1] && req.param[16];
    if (t_low) begin
      st_i = req.degree;
      st_s = '0;
    end else if (t_high) begin
      st_i = 3'(req.count - 4'd1);
      st_s = {st_m, 16'b0};
    end else begin
      st_i = req.degree + st_mt[18:16];
      st_s = st_mt;
    end
  end

  // Operand selection for the current term
  logic [4:0]         k5, j5;
  logic [3:0]         ka, kb, kc, kd, span0, span1;
  logic signed [20:0] n0, n1;
  logic               t_act;
  logic signed [20:0] t_n;
  logic signed [35:0] t_m;
  logic signed [47:0] t_add;
  logic [3:0]         t_span;

  always_comb begin
    k5    = {2'b0, i_r} - {2'b0, r_r};
    j5    = {2'b0, j_r};
    ka    = knot_at(k5 + j5, d_r, m_r);
    kb    = knot_at(k5, d_r, m_r);
    kc    = knot_at(k5 + j5 + 5'd1, d_r, m_r);
    kd    = knot_at(k5 + 5'd1, d_r, m_r);
    span0 = ka - kb;
    span1 = kc - kd;
    n0    = $signed({1'b0, s_r}) - $signed({1'b0, kb, 16'b0});
    n1    = $signed({1'b0, kc, 16'b0}) - $signed({1'b0, s_r});
    t_act = 1'b0;
    t_n   = n0;
    t_m   = cur_b;
    t_add = '0;
    t_span = span0;
    case (term_r)
      2'd0: begin
        t_act = (r_r < j_r) && (span0 != 4'd0);
      end
      2'd1: begin
        t_act = (r_r != 3'd0) && (span1 != 4'd0);
        t_n = n1; t_m = prev_b; t_span = span1;
      end
      2'd2: begin
        t_act = deriv_r && (r_r < j_r) && (span0 != 4'd0);
        t_m = cur_db; t_add = 48'(cur_b) <<< 16;
      end
      default: begin
        t_act = deriv_r && (r_r != 3'd0) && (span1 != 4'd0);
        t_n = n1; t_m = prev_db; t_span = span1;
        t_add = -(48'(prev_b) <<< 16);
      end
    endcase
  end

  // Numerator magnitude, rounded half-divisor bias, scaled down by 2^16
  logic signed [57:0] num;
  logic [57:0]        mag;
  logic [58:0]        biased;

  always_comb begin
    num    = (58'(p_hi) <<< 18) + 58'(p_lo) + 58'(op_add);
    mag    = num[57] ? 58'(-num) : 58'(num);
    biased = 59'(mag) + (59'(op_span) << 15);
  end

  // Eight restoring steps per cycle against a divisor of at most 8
  logic [47:0] dv_step;
  logic [3:0]  rem_step;
  logic [4:0]  trial;

  always_comb begin
    dv_step  = dv;
    rem_step = rem;
    for (int s = 0; s < 8; s++) begin
      trial   = {rem_step, dv_step[47]};
      dv_step = dv_step << 1;
      if (trial >= {1'b0, op_span}) begin
        rem_step   = 4'(trial - {1'b0, op_span});
        dv_step[0] = 1'b1;
      end else begin
        rem_step = trial[3:0];
      end
    end
  end

  logic signed [39:0] quot;
  assign quot = neg ? -$signed(dv[39:0]) : $signed(dv[39:0]);

  // Weight output
  logic [2:0]         out_r;
  logic signed [40:0] dscaled;

  always_comb begin
    out_r   = d_r - kout_r;
    dscaled = dbq[out_r] * $signed({1'b0, m_r});
    rsp        = '0;
    rsp.wvalid = (state == B_OUT);
    rsp.windex = kout_r;
    rsp.wdata  = deriv_r ? WEIGHT_BITS'(round_shift(72'(dscaled), 6))
                         : WEIGHT_BITS'(round_shift(72'(bq[out_r]), 6));
    rsp.done   = (state == B_DONE);
    rsp.first  = i_r - d_r;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (req.start) begin
            m_r     <= st_m;
            d_r     <= req.degree;
            i_r     <= st_i;
            s_r     <= st_s;
            deriv_r <= req.deriv;
            j_r     <= 3'd1;
            r_r     <= 3'd0;
            kout_r  <= 3'd0;
            for (int e = 0; e < PTS_AXIS; e++) begin
              bq[e]  <= (e == 0) ? (36'sd1 <<< 30) : '0;
              dbq[e] <= '0;
            end
            state <= (req.degree == 3'd0) ? B_OUT : B_ENTRY;
          end
        end
        B_ENTRY: begin
          cur_b  <= bq[r_r];
          cur_db <= dbq[r_r];
          nb     <= '0;
          nd     <= '0;
          term_r <= 2'd0;
          state  <= B_TERM;
        end
        B_TERM: begin
          op_n    <= t_n;
          op_m    <= t_m;
          op_add  <= t_add;
          op_span <= t_span;
          op_dst  <= term_r[1];
          if (t_act) state <= B_MUL;
          else if (term_r == 2'd3) state <= B_WRITE;
          else term_r <= term_r + 2'd1;
        end
        B_MUL: begin
          p_lo  <= op_n * $signed({1'b0, op_m[17:0]});
          p_hi  <= op_n * $signed(op_m[35:18]);
          state <= B_NUM;
        end
        B_NUM: begin
          dv      <= {5'b0, biased[58:16]};
          rem     <= '0;
          neg     <= num[57];
          div_cnt <= '0;
          state   <= B_DIV;
        end
        B_DIV: begin
          dv      <= dv_step;
          rem     <= rem_step;
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd5) state <= B_ACC;
        end
        B_ACC: begin
          if (op_dst) nd <= nd + quot;
          else nb <= nb + quot;
          if (term_r == 2'd3) begin
            state <= B_WRITE;
          end else begin
            term_r <= term_r + 2'd1;
            state  <= B_TERM;
          end
        end
        B_WRITE: begin
          bq[r_r]  <= nb[35:0];
          dbq[r_r] <= nd[35:0];
          prev_b   <= cur_b;
          prev_db  <= cur_db;
          if (r_r == j_r) begin
            r_r <= 3'd0;
            if (j_r == d_r) begin
              state <= B_OUT;
            end else begin
              j_r   <= j_r + 3'd1;
              state <= B_ENTRY;
            end
          end else begin
            r_r   <= r_r + 3'd1;
            state <= B_ENTRY;
          end
        end
        B_OUT: begin
          kout_r <= kout_r + 3'd1;
          if (kout_r == d_r) state <= B_DONE;
        end
        B_DONE: begin
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bspline_volume_evaluator_core.sv
// Top level of the trivariate B-spline volume evaluator: lattice store,
// weighted-sum pipeline and stream ports. Depends on bve_pkg and bve_basis.
`default_nettype none

// After reset the block clears its 512-entry lattice store, one entry per cycle,
// and holds s_tready low until the clearing is done. A point write returns
// nothing. An evaluation builds the basis of each axis in turn in one shared
// engine, then streams (du+1)(dv+1)(dw+1) lattice reads through a four-stage
// multiply pipeline at one point per cycle. Each axis works through d(d+3)/2
// recursion entries of four term slots each (up to two active for position
// and four on the derivative axis); an active slot passes the shared multiply
// and the serial divider. The engine then hands out the weights. The result
// waits in an output register while the next transaction is taken; a new
// evaluation finishes only once it is free.
module bspline_volume_evaluator_core import bve_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // tdata: index_u, index_v, index_w, point_x, point_y, point_z,
  //        param_u, param_v, param_w, one zero pad bit
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,
  input  logic [2:0]   s_tuser,    // req_type
  // tdata: result_x, result_y, result_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,
  output logic         m_tuser,    // saturated
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  typedef enum logic [2:0] {
    T_CLEAR, T_IDLE, T_BSTART, T_BWAIT, T_SUM, T_DRAIN, T_OUT
  } tstate_t;

  tstate_t state;

  // Configuration
  logic [3:0] cnt_u, cnt_v, cnt_w;
  logic [2:0] deg_u, deg_v, deg_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_u <= 4'd4; cnt_v <= 4'd4; cnt_w <= 4'd4;
      deg_u <= 3'd3; deg_v <= 3'd3; deg_w <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT_U:  cnt_u <= cfg_data;
        CFG_COUNT_V:  cnt_v <= cfg_data;
        CFG_COUNT_W:  cnt_w <= cfg_data;
        CFG_DEGREE_U: deg_u <= cfg_data[2:0];
        CFG_DEGREE_V: deg_v <= cfg_data[2:0];
        CFG_DEGREE_W: deg_w <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  function automatic logic [3:0] eff_count(input logic [3:0] c);
    if (c < 4'd2) return 4'd2;
    else if (c > 4'(PTS_AXIS)) return 4'(PTS_AXIS);
    else return c;
  endfunction

  function automatic logic [2:0] eff_degree(input logic [2:0] g, input logic [3:0] n);
    logic [3:0] lim;
    lim = n - 4'd1;
    if ({1'b0, g} > lim) return lim[2:0];
    else return g;
  endfunction

  logic [3:0] n_u, n_v, n_w;
  logic [2:0] d_u, d_v, d_w;

  assign n_u = eff_count(cnt_u);
  assign n_v = eff_count(cnt_v);
  assign n_w = eff_count(cnt_w);
  assign d_u = eff_degree(deg_u, n_u);
  assign d_v = eff_degree(deg_v, n_v);
  assign d_w = eff_degree(deg_w, n_w);

  // Input transaction fields
  logic                         in_acc;
  req_type_t                    in_req;
  logic [ADDR_BITS-1:0]         in_addr;
  logic [3*COORD_BITS-1:0]      in_point;

  assign s_tready = (state == T_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_req   = req_type_t'(s_tuser);
  // Store address is {u, v, w}
  assign in_addr  = {s_tdata[2:0], s_tdata[5:3], s_tdata[8:6]};
  assign in_point = s_tdata[104:9];

  // Lattice store: {z, y, x} per entry
  logic [3*COORD_BITS-1:0] store [STORE_DEPTH];
  logic [3*COORD_BITS-1:0] store_q;
  logic [ADDR_BITS:0]      clr_addr;
  logic                    st_we;
  logic [ADDR_BITS-1:0]    st_waddr, st_raddr;
  logic [3*COORD_BITS-1:0] st_wdata;

  assign st_we    = (state == T_CLEAR) || (in_acc && in_req == REQ_WRITE);
  assign st_waddr = (state == T_CLEAR) ? clr_addr[ADDR_BITS-1:0] : in_addr;
  assign st_wdata = (state == T_CLEAR) ? '0 : in_point;

  always_ff @(posedge clk) begin
    if (st_we) store[st_waddr] <= st_wdata;
    store_q <= store[st_raddr];
  end

  // Latched evaluation request
  req_type_t                    req_r;
  logic signed [PARAM_BITS-1:0] par_u, par_v, par_w;
  logic [1:0]                   axis;
  logic [IDX_BITS-1:0]          first_u, first_v, first_w;
  logic signed [WEIGHT_BITS-1:0] wt_u [PTS_AXIS];
  logic signed [WEIGHT_BITS-1:0] wt_v [PTS_AXIS];
  logic signed [WEIGHT_BITS-1:0] wt_w [PTS_AXIS];

  // Basis engine
  basis_req_t breq;
  basis_rsp_t brsp;

  always_comb begin
    breq       = '0;
    breq.start = (state == T_BSTART);
    case (axis)
      2'd0: begin
        breq.count = n_u; breq.degree = d_u; breq.param = par_u;
        breq.deriv = (req_r == REQ_DU);
      end
      2'd1: begin
        breq.count = n_v; breq.degree = d_v; breq.param = par_v;
        breq.deriv = (req_r == REQ_DV);
      end
      default: begin
        breq.count = n_w; breq.degree = d_w; breq.param = par_w;
        breq.deriv = (req_r == REQ_DW);
      end
    endcase
  end

  bve_basis u_basis (
    .clk (clk),
    .rst (rst),
    .req (breq),
    .rsp (brsp)
  );

  always_ff @(posedge clk) begin
    if (brsp.wvalid) begin
      case (axis)
        2'd0:    wt_u[brsp.windex] <= brsp.wdata;
        2'd1:    wt_v[brsp.windex] <= brsp.wdata;
        default: wt_w[brsp.windex] <= brsp.wdata;
      endcase
    end
  end

  // Weighted-sum pipeline: issue, weight uv, weight uvw, point products
  logic [IDX_BITS-1:0] ca, cb, cc, c_b;
  logic                v_b, v_c, v_d, issue, last_pt;
  logic signed [63:0]  p_uv;
  logic signed [33:0]  w_uv, w_3;
  logic signed [65:0]  p_3;
  logic [3*COORD_BITS-1:0] pt_c;
  logic signed [65:0]  prod_x, prod_y, prod_z;
  logic signed [55:0]  acc_x, acc_y, acc_z;

  assign issue    = (state == T_SUM);
  assign last_pt  = (ca == d_u) && (cb == d_v) && (cc == d_w);
  assign st_raddr = {3'(first_u + ca), 3'(first_v + cb), 3'(first_w + cc)};
  assign w_uv     = 34'(round_shift(72'(p_uv), 24));
  assign w_3      = 34'(round_shift(72'(p_3), 24));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      v_b <= issue;
      v_c <= v_b;
      v_d <= v_c;
    end
    p_uv   <= wt_u[ca] * wt_v[cb];
    c_b    <= cc;
    p_3    <= w_uv * wt_w[c_b];
    pt_c   <= store_q;
    prod_x <= $signed(pt_c[31:0]) * w_3;
    prod_y <= $signed(pt_c[63:32]) * w_3;
    prod_z <= $signed(pt_c[95:64]) * w_3;
    if (in_acc) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end else if (v_d) begin
      acc_x <= acc_x + 56'(round_shift(72'(prod_x), 24));
      acc_y <= acc_y + 56'(round_shift(72'(prod_y), 24));
      acc_z <= acc_z + 56'(round_shift(72'(prod_z), 24));
    end
  end

  // Saturation to the coordinate range
  localparam logic signed [55:0] CMAX = 56'sd2147483647;
  localparam logic signed [55:0] CMIN = -56'sd2147483648;

  function automatic logic [COORD_BITS:0] sat_coord(input logic signed [55:0] v);
    if (v > CMAX) return {1'b1, CMAX[COORD_BITS-1:0]};
    else if (v < CMIN) return {1'b1, CMIN[COORD_BITS-1:0]};
    else return {1'b0, v[COORD_BITS-1:0]};
  endfunction

  logic [COORD_BITS:0] sx, sy, sz;
  assign sx = sat_coord(acc_x);
  assign sy = sat_coord(acc_y);
  assign sz = sat_coord(acc_z);

  // Control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_CLEAR;
      clr_addr <= '0;
      axis     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == T_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        T_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (ADDR_BITS+1)'(STORE_DEPTH - 1)) state <= T_IDLE;
        end
        T_IDLE: begin
          if (in_acc) begin
            case (in_req)
              REQ_POS, REQ_DU, REQ_DV, REQ_DW: begin
                req_r <= in_req;
                par_u <= s_tdata[122:105];
                par_v <= s_tdata[140:123];
                par_w <= s_tdata[158:141];
                axis  <= 2'd0;
                state <= T_BSTART;
              end
              default: ;
            endcase
          end
        end
        T_BSTART: begin
          state <= T_BWAIT;
        end
        T_BWAIT: begin
          if (brsp.done) begin
            case (axis)
              2'd0:    first_u <= brsp.first;
              2'd1:    first_v <= brsp.first;
              default: first_w <= brsp.first;
            endcase
            if (axis == 2'd2) begin
              ca    <= '0;
              cb    <= '0;
              cc    <= '0;
              state <= T_SUM;
            end else begin
              axis  <= axis + 2'd1;
              state <= T_BSTART;
            end
          end
        end
        T_SUM: begin
          if (last_pt) begin
            state <= T_DRAIN;
          end else if (cc == d_w) begin
            cc <= '0;
            if (cb == d_v) begin
              cb <= '0;
              ca <= ca + 3'd1;
            end else begin
              cb <= cb + 3'd1;
            end
          end else begin
            cc <= cc + 3'd1;
          end
        end
        T_DRAIN: begin
          if (!v_b && !v_c && !v_d) state <= T_OUT;
        end
        T_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {sz[COORD_BITS-1:0], sy[COORD_BITS-1:0], sx[COORD_BITS-1:0]};
            m_tuser  <= sx[COORD_BITS] | sy[COORD_BITS] | sz[COORD_BITS];
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bve_checker.sv
// Port-level checks for the B-spline volume evaluator, bound to the top level.
// Depends on bve_pkg and bspline_volume_evaluator_core.
`default_nettype none

module bve_checker import bve_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [2:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic         m_tuser
);

  // Store clearing keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input open during store clearing");

  // An accepted evaluation transaction closes the input (checked right after acceptance)
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_POS || s_tuser == REQ_DU ||
      s_tuser == REQ_DV || s_tuser == REQ_DW) |=> !s_tready)
    else $error("input open during evaluation");

  // A pending result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The saturation flag comes only with a clipped coordinate
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
      m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
      m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000)
    else $error("saturation flag without clipped coordinate");

endmodule

bind bspline_volume_evaluator_core bve_checker u_checker (.*);

`default_nettype wire
